>>> src/firc_pkg.sv
// Shared types and constants for the FIR impulse response convolver.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package firc_pkg;

  // Defaults for the top level parameters.
  localparam int MAX_TAPS_DEF    = 8192;
  localparam int SAMPLE_BITS_DEF = 24;

  // Fixed field widths.
  localparam int COEF_INDEX_BITS = 13;
  localparam int TAP_COUNT_BITS  = 14;
  localparam int GAIN_BITS       = 16;
  localparam int GAIN_FRAC       = 15;
  localparam int CFG_INDEX_BITS  = 8;
  localparam int CFG_DATA_BITS   = 16;

  // Accumulator and gain scaling widths.
  localparam int ACC_BITS  = 64;
  localparam int HALF_BITS = ACC_BITS / 2;
  localparam int PART_BITS = HALF_BITS + GAIN_BITS;
  localparam int SCL_BITS  = ACC_BITS + GAIN_BITS;

  // Register indexes on the configuration channel.
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_COUNT = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN      = CFG_INDEX_BITS'(1);

  localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = TAP_COUNT_BITS'(1);
  localparam logic [GAIN_BITS-1:0]      GAIN_RESET      = GAIN_BITS'(4125);

  // Operation codes of an input item.
  localparam logic OP_COEF   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic clr;       // write zero to both stores at the sweep address
    logic coef_wr;   // write one coefficient
    logic start;     // take a sample, set up the tap walk
    logic issue;     // read one tap pair
    logic mag;       // take the magnitude of the sum
    logic mul_lo;    // low half of the gain product
    logic mul_hi;    // high half of the gain product
    logic load_out;  // round, saturate and load the output register
  } firc_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_last;
    logic last_tap;
    logic pipe_empty;
    logic taps_zero;
    logic out_free;
  } firc_sts_t;

endpackage

>>> src/firc_if.sv
// Channel interfaces of the convolver: sample/coefficient input, result output
// and configuration writes. Depends on firc_pkg.
interface firc_item_if #(parameter int SAMPLE_BITS = firc_pkg::SAMPLE_BITS_DEF) ();
  import firc_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [COEF_INDEX_BITS-1:0]    coef_index;
  logic signed [SAMPLE_BITS-1:0] value;

  modport source(output valid, operation, coef_index, value, input ready);
  modport sink(input valid, operation, coef_index, value, output ready);
endinterface

interface firc_result_if #(parameter int SAMPLE_BITS = firc_pkg::SAMPLE_BITS_DEF) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          saturated;

  modport source(output valid, sample_out, saturated, input ready);
  modport sink(input valid, sample_out, saturated, output ready);
endinterface

interface firc_cfg_if ();
  import firc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> src/firc_ctrl.sv
// Sequencer of the convolver: clearing sweep, tap walk, gain scaling, output.
// Depends on firc_pkg; drives firc_dp through firc_cmd_t.
module firc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_operation,
  output logic                item_ready,
  input  firc_pkg::firc_sts_t sts,
  output firc_pkg::firc_cmd_t cmd
);
  import firc_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MAC    = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_MAG    = 3'd4;
  localparam logic [2:0] S_MUL_LO = 3'd5;
  localparam logic [2:0] S_MUL_HI = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item_operation == OP_SAMPLE) begin
            cmd.start  = 1'b1;
            state_next = sts.taps_zero ? S_DRAIN : S_MAC;
          end else begin
            cmd.coef_wr = 1'b1;
          end
        end
      end
      S_MAC: begin
        cmd.issue = 1'b1;
        if (sts.last_tap) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          state_next = S_MAG;
        end
      end
      S_MAG: begin
        cmd.mag    = 1'b1;
        state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // Wait here only while the previous result has not been taken.
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // A new item must never meet taps still in flight.
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> sts.pipe_empty)
    else $error("item accepted with the tap pipeline busy");

  // The tap walk only starts when there is at least one tap.
  a_start_taps: assert property (@(posedge clk) disable iff (rst)
    (cmd.start && !sts.taps_zero) |=> (state == S_MAC))
    else $error("tap walk did not start");

  // The output step always follows the high gain product.
  a_mul_order: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_hi |=> (state == S_OUT))
    else $error("scaling sequence out of order");

endmodule

>>> src/firc_dp.sv
// Datapath of the convolver: coefficient and history stores, the shared
// multiply-accumulate pipeline, gain scaling, rounding, saturation, output register.
// Depends on firc_pkg; sequenced by firc_ctrl.
module firc_dp #(
  parameter int MAX_TAPS    = firc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = firc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  firc_pkg::firc_cmd_t                     cmd,
  output firc_pkg::firc_sts_t                     sts,
  input  logic [firc_pkg::COEF_INDEX_BITS-1:0]    coef_index,
  input  logic signed [SAMPLE_BITS-1:0]           value,
  input  logic                                    cfg_wr,
  input  logic [firc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [firc_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [SAMPLE_BITS-1:0]           sample_out,
  output logic                                    saturated
);
  import firc_pkg::*;

  localparam int AW          = $clog2(MAX_TAPS);
  localparam int CW          = $clog2(MAX_TAPS + 1);
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int SCALE_SHIFT = SAMPLE_BITS - 1 + GAIN_FRAC;
  localparam int QW          = SCL_BITS + 1;

  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

  // Configuration registers.
  logic [TAP_COUNT_BITS-1:0] tap_count;
  logic [GAIN_BITS-1:0]      gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RESET;
      gain      <= GAIN_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_TAP_COUNT: tap_count <= cfg_data[TAP_COUNT_BITS-1:0];
        REG_GAIN:      gain      <= cfg_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Stores and their address counters.
  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic [AW-1:0]                 clr_addr;
  logic [AW-1:0]                 wp;
  logic [AW-1:0]                 pos;
  logic [CW-1:0]                 k;
  logic [CW-1:0]                 taps;
  logic                          coef_in_range;

  assign coef_in_range = 32'(coef_index) < 32'(MAX_TAPS);

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      coef_mem[clr_addr] <= '0;
    end else if (cmd.coef_wr && coef_in_range) begin
      coef_mem[AW'(coef_index)] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      hist_mem[clr_addr] <= '0;
    end else if (cmd.start) begin
      hist_mem[wp] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      wp       <= '0;
    end else begin
      if (cmd.clr) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.start) begin
        wp <= (wp == LAST_ADDR) ? '0 : wp + AW'(1);
      end
    end
  end

  // Tap walk: k runs up over the coefficients, pos runs back through the ring.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      k    <= '0;
      pos  <= wp;
      taps <= (32'(tap_count) > 32'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(tap_count);
    end else if (cmd.issue) begin
      k   <= k + CW'(1);
      pos <= (pos == '0) ? LAST_ADDR : pos - AW'(1);
    end
  end

  // Read, multiply and accumulate stages.
  logic signed [SAMPLE_BITS-1:0] coef_rd;
  logic signed [SAMPLE_BITS-1:0] hist_rd;
  logic                          rd_vld;
  logic signed [PROD_BITS-1:0]   prod;
  logic                          prod_vld;
  logic [ACC_BITS-1:0]           acc;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      coef_rd <= coef_mem[k[AW-1:0]];
      hist_rd <= hist_mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    prod <= coef_rd * hist_rd;
    if (cmd.start) begin
      acc <= '0;
    end else if (prod_vld) begin
      // The sum wraps at the accumulator width.
      acc <= acc + ACC_BITS'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= cmd.issue;
      prod_vld <= rd_vld;
    end
  end

  // Gain scaling on the magnitude, split into two 32 by 16 products.
  logic                  neg;
  logic [ACC_BITS-1:0]   mag;
  logic [PART_BITS-1:0]  part_lo;
  logic [PART_BITS-1:0]  part_hi;
  logic [SCL_BITS-1:0]   scaled;

  assign part_hi = PART_BITS'(mag[ACC_BITS-1:HALF_BITS]) * PART_BITS'(gain);

  always_ff @(posedge clk) begin
    if (cmd.mag) begin
      neg <= acc[ACC_BITS-1];
      mag <= acc[ACC_BITS-1] ? (~acc + ACC_BITS'(1)) : acc;
    end
    if (cmd.mul_lo) begin
      part_lo <= PART_BITS'(mag[HALF_BITS-1:0]) * PART_BITS'(gain);
    end
    if (cmd.mul_hi) begin
      scaled <= SCL_BITS'(part_lo) + (SCL_BITS'(part_hi) << HALF_BITS);
    end
  end

  // Round half away from zero, then clip the magnitude.
  logic [QW-1:0]          rounded;
  logic [QW-1:0]          q;
  logic [QW-1:0]          limit;
  logic [SAMPLE_BITS-1:0] q_clip;
  logic                   clip;

  always_comb begin
    rounded = QW'(scaled) + (QW'(1) << (SCALE_SHIFT - 1));
    q       = rounded >> SCALE_SHIFT;
    limit   = QW'(1) << (SAMPLE_BITS - 1);
    if (neg) begin
      clip   = q > limit;
      q_clip = clip ? SAMPLE_BITS'(limit) : SAMPLE_BITS'(q);
    end else begin
      clip   = q > (limit - QW'(1));
      q_clip = clip ? SAMPLE_BITS'(limit - QW'(1)) : SAMPLE_BITS'(q);
    end
  end

  // Output register: the next sample is taken while a result waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sample_out <= neg ? -$signed(q_clip) : $signed(q_clip);
      saturated  <= clip;
    end
  end

  assign sts.clr_last   = (clr_addr == LAST_ADDR);
  assign sts.last_tap   = ((k + CW'(1)) == taps);
  assign sts.pipe_empty = !rd_vld && !prod_vld;
  assign sts.taps_zero  = (tap_count == '0);
  assign sts.out_free   = !out_valid || out_ready;

  a_pipe_flow: assert property (@(posedge clk) disable iff (rst)
    rd_vld |=> prod_vld)
    else $error("read stage lost a tap");

  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (k < taps))
    else $error("tap read beyond the tap count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwritten before transfer");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (sample_out == $signed({1'b0, {(SAMPLE_BITS - 1){1'b1}}})) ||
      (sample_out == $signed({1'b1, {(SAMPLE_BITS - 1){1'b0}}})))
    else $error("saturation flag without a clipped value");

endmodule

>>> src/fir_impulse_response_convolver_core.sv
// Top level of the FIR impulse response convolver.
// Depends on firc_pkg, firc_if, firc_ctrl and firc_dp.
//
//   channel  dir  payload                               transfer
//   item     in   operation, coef_index, value          valid & ready
//   result   out  sample_out, saturated                 valid & ready
//   cfg      in   index (0 tap_count, 1 gain), data     valid & ready
//
// A coefficient write is taken in the idle state. For a sample the single shared
// multiply-accumulate reads min(tap_count, MAX_TAPS) tap pairs, one per cycle (none
// when tap_count is 0), followed by pipeline drain, magnitude, two gain partial
// products and output; the next item is taken once the output register is loaded.
// After reset a clearing sweep zeroes both stores, during which item.ready is low;
// cfg is always ready.
// A stalled result holds in the output register; the next item is still taken
// and its result waits in the last step until the register frees.
module fir_impulse_response_convolver_core #(
  parameter int MAX_TAPS    = firc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = firc_pkg::SAMPLE_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  firc_item_if.sink    item,
  firc_result_if.source result,
  firc_cfg_if.sink     cfg
);
  import firc_pkg::*;

  firc_cmd_t cmd;
  firc_sts_t sts;

  assign cfg.ready = 1'b1;

  firc_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item.valid),
    .item_operation (item.operation),
    .item_ready     (item.ready),
    .sts            (sts),
    .cmd            (cmd)
  );

  firc_dp #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .coef_index (item.coef_index),
    .value      (item.value),
    .cfg_wr     (cfg.valid && cfg.ready),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .sample_out (result.sample_out),
    .saturated  (result.saturated)
  );

endmodule

>>> tb/fir_impulse_response_convolver_core_tb.sv
// Self-checking testbench for the FIR impulse response convolver core.
// Needs firc_pkg, the channel interfaces in firc_if and the core RTL; it reads nothing else.
// A directed table runs first, then random phases checked against a fixed-point convolution.
module fir_impulse_response_convolver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import firc_pkg::*;

  localparam int MAX_TAPS      = MAX_TAPS_DEF;
  localparam int SAMPLE_BITS   = SAMPLE_BITS_DEF;
  localparam int CLK_PERIOD    = 10;
  localparam int SCALE_SHIFT   = SAMPLE_BITS - 1 + GAIN_FRAC;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_PHASES = 8;
  localparam int BIG_PHASE     = 4;

  // Indexes that name no register; writes to them must change nothing.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOP   = '1;

  localparam logic signed [SAMPLE_BITS-1:0] VALUE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] VALUE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(1 << GAIN_FRAC);
  localparam logic [GAIN_BITS-1:0] GAIN_MAX   = '1;
  localparam logic [80:0] SAT_LIMIT = 81'(1) << (SAMPLE_BITS - 1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          saturated;
  } filtered_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [CFG_INDEX_BITS-1:0]     reg_index;
    logic [CFG_DATA_BITS-1:0]      reg_data;
    logic                          operation;
    logic [COEF_INDEX_BITS-1:0]    coef_index;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          known;
    filtered_t                     want;
  } row_t;

  logic clk;
  logic rst;

  firc_item_if #(.SAMPLE_BITS(SAMPLE_BITS)) item_if ();
  firc_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_if ();
  firc_cfg_if cfg_if ();

  fir_impulse_response_convolver_core #(
    .MAX_TAPS(MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .item(item_if),
    .result(result_if),
    .cfg(cfg_if)
  );

  // Predictor state, mirrored from the block.
  logic signed [SAMPLE_BITS-1:0] coef_store [MAX_TAPS] = '{default: '0};
  logic signed [SAMPLE_BITS-1:0] history_ring [MAX_TAPS] = '{default: '0};
  logic [COEF_INDEX_BITS-1:0] ring_pos = '0;
  logic [TAP_COUNT_BITS-1:0] taps_reg = TAP_COUNT_RESET;
  logic [GAIN_BITS-1:0] gain_reg = GAIN_RESET;

  filtered_t expected_outputs [$];
  row_t stim_rows [$];
  int mismatch_count = 0;
  int burst_left = 0;
  int cycle_count = 0;
  bit hold_request = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Store the sample, walk the taps backwards through the ring, scale by gain,
  // round half away from zero and clip to the sample range.
  function automatic filtered_t convolve_sample(input logic signed [SAMPLE_BITS-1:0] s);
    filtered_t r;
    longint acc;
    int n;
    int pos;
    logic [63:0] acc_bits;
    logic [63:0] mag;
    logic [80:0] q;
    logic neg;
    history_ring[ring_pos] = s;
    n = (int'(taps_reg) > MAX_TAPS) ? MAX_TAPS : int'(taps_reg);
    acc = 0;
    for (int k = 0; k < n; k++) begin
      pos = int'(ring_pos) - k;
      if (pos < 0) pos += MAX_TAPS;
      acc += longint'(coef_store[k]) * longint'(history_ring[pos]);
    end
    ring_pos = (int'(ring_pos) + 1 >= MAX_TAPS) ? '0 : ring_pos + 1'b1;
    acc_bits = acc;
    neg = acc_bits[63];
    mag = neg ? (~acc_bits + 64'd1) : acc_bits;
    q = (81'(mag) * 81'(gain_reg) + (81'd1 << (SCALE_SHIFT - 1))) >> SCALE_SHIFT;
    r.saturated = 1'b0;
    if (neg) begin
      if (q > SAT_LIMIT) begin
        q = SAT_LIMIT;
        r.saturated = 1'b1;
      end
      r.sample_out = SAMPLE_BITS'(~q + 81'd1);
    end else begin
      if (q > SAT_LIMIT - 81'd1) begin
        q = SAT_LIMIT - 81'd1;
        r.saturated = 1'b1;
      end
      r.sample_out = SAMPLE_BITS'(q);
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return VALUE_MIN;
      1: return VALUE_MAX;
      2: return '0;
      3: return SAMPLE_BITS'($signed($urandom_range(0, 512)) - 256);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic row_t cfg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                   input logic [CFG_DATA_BITS-1:0] data);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_index = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic row_t coef_row(input logic [COEF_INDEX_BITS-1:0] idx,
                                    input logic signed [SAMPLE_BITS-1:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.operation = OP_COEF;
    r.coef_index = idx;
    r.value = val;
    return r;
  endfunction

  function automatic row_t sample_row(input logic signed [SAMPLE_BITS-1:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.operation = OP_SAMPLE;
    r.value = val;
    return r;
  endfunction

  function automatic row_t sample_known(input logic signed [SAMPLE_BITS-1:0] val,
                                        input logic signed [SAMPLE_BITS-1:0] out,
                                        input logic sat);
    row_t r;
    r = sample_row(val);
    r.known = 1'b1;
    r.want.sample_out = out;
    r.want.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // The sender runs in bursts; before a new burst a gap may lower valid first.
  task automatic send_item(input logic op, input logic [COEF_INDEX_BITS-1:0] idx,
                           input logic signed [SAMPLE_BITS-1:0] val,
                           input logic known, input filtered_t want);
    filtered_t pred;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 12);
    end
    item_if.valid <= 1'b1;
    item_if.operation <= op;
    item_if.coef_index <= idx;
    item_if.value <= val;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    burst_left--;
    if (op == OP_SAMPLE) begin
      pred = convolve_sample(val);
      expected_outputs.push_back(known ? want : pred);
    end else if (int'(idx) < MAX_TAPS) begin
      coef_store[idx] = val;
    end
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_TAP_COUNT: taps_reg = data[TAP_COUNT_BITS-1:0];
      REG_GAIN:      gain_reg = data[GAIN_BITS-1:0];
      default:       ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // A coefficient write gives no result, so after the expected results drain, also let the last one settle.
  task automatic wait_idle();
    item_if.valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fir_impulse_response_convolver_core test failed");
      $finish;
    end
  end

  // Receiver: alternating ready and stall stretches, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= LONG_HOLD;
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (result_if.ready) begin
      result_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      result_if.ready <= 1'b1;
      stall_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(0, 20);
    end
  end

  always @(posedge clk) begin
    filtered_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_outputs.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", result_if.sample_out));
      end else begin
        want = expected_outputs.pop_front();
        if (result_if.sample_out !== want.sample_out)
          report_mismatch($sformatf("sample_out %0d, expected %0d",
                                    result_if.sample_out, want.sample_out));
        if (result_if.saturated !== want.saturated)
          report_mismatch($sformatf("saturated %0b, expected %0b",
                                    result_if.saturated, want.saturated));
      end
    end
  end

  initial begin
    int cur_taps;
    int idx_hi;
    int n_items;
    logic op;
    rst = 1'b1;
    item_if.valid <= 1'b0;
    item_if.operation <= OP_COEF;
    item_if.coef_index <= '0;
    item_if.value <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_TAP_COUNT;
    cfg_if.data <= '0;

    // Defaults after reset, zero taps, unity and full gain, clipping both ways,
    // zero gain, a tap count beyond the store, and writes to missing registers.
    stim_rows.push_back(sample_known(SAMPLE_BITS'(24'h123456), '0, 1'b0));
    stim_rows.push_back(cfg_row(REG_TAP_COUNT, '0));
    stim_rows.push_back(coef_row('0, VALUE_MAX));
    stim_rows.push_back(sample_known(VALUE_MAX, '0, 1'b0));
    stim_rows.push_back(cfg_row(REG_GAIN, GAIN_UNITY));
    stim_rows.push_back(cfg_row(REG_TAP_COUNT, CFG_DATA_BITS'(1)));
    stim_rows.push_back(coef_row('0, VALUE_MIN));
    stim_rows.push_back(sample_known(VALUE_MIN, VALUE_MAX, 1'b1));
    stim_rows.push_back(sample_row(VALUE_MAX));
    stim_rows.push_back(sample_known('0, '0, 1'b0));
    stim_rows.push_back(coef_row('1, SAMPLE_BITS'(24'h5A5A5A)));
    stim_rows.push_back(coef_row(COEF_INDEX_BITS'(1), VALUE_MAX));
    stim_rows.push_back(coef_row(COEF_INDEX_BITS'(2), VALUE_MIN));
    stim_rows.push_back(cfg_row(REG_TAP_COUNT, CFG_DATA_BITS'(3)));
    stim_rows.push_back(cfg_row(REG_GAIN, GAIN_MAX));
    stim_rows.push_back(sample_row(VALUE_MIN));
    stim_rows.push_back(sample_row(VALUE_MIN));
    stim_rows.push_back(coef_row('0, VALUE_MAX));
    stim_rows.push_back(sample_row(VALUE_MIN));
    stim_rows.push_back(cfg_row(REG_GAIN, '0));
    stim_rows.push_back(sample_known(VALUE_MAX, '0, 1'b0));
    stim_rows.push_back(cfg_row(REG_GAIN, GAIN_RESET));
    stim_rows.push_back(cfg_row(REG_TAP_COUNT, '1));
    stim_rows.push_back(sample_row(SAMPLE_BITS'(24'h7F0001)));
    stim_rows.push_back(cfg_row(REG_SPARE, '1));
    stim_rows.push_back(cfg_row(REG_TOP, '0));
    stim_rows.push_back(sample_row(SAMPLE_BITS'(24'h800001)));
    stim_rows.push_back(cfg_row(REG_TAP_COUNT, CFG_DATA_BITS'(MAX_TAPS)));
    stim_rows.push_back(sample_row(SAMPLE_BITS'(24'h2AAAAA)));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_register(stim_rows[i].reg_index, stim_rows[i].reg_data);
      end else begin
        send_item(stim_rows[i].operation, stim_rows[i].coef_index, stim_rows[i].value,
                  stim_rows[i].known, stim_rows[i].want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      if (ph == BIG_PHASE) begin
        cur_taps = $urandom_range(0, 1) ? MAX_TAPS : (1 << TAP_COUNT_BITS) - 1;
        n_items = 4;
      end else begin
        case ($urandom_range(0, 7))
          0:       cur_taps = 0;
          1:       cur_taps = 1;
          default: cur_taps = $urandom_range(2, 24);
        endcase
        n_items = $urandom_range(10, 16);
      end
      write_register(REG_TAP_COUNT, CFG_DATA_BITS'(cur_taps));
      case ($urandom_range(0, 5))
        0:       write_register(REG_GAIN, '0);
        1:       write_register(REG_GAIN, GAIN_MAX);
        2:       write_register(REG_GAIN, GAIN_UNITY);
        default: write_register(REG_GAIN, CFG_DATA_BITS'($urandom()));
      endcase
      if ($urandom_range(0, 3) == 0)
        write_register($urandom_range(0, 1) ? REG_SPARE : REG_TOP, CFG_DATA_BITS'($urandom()));
      // Stall the receiver for a long stretch so the core backs up into its input.
      if (ph == 1) hold_request <= 1'b1;
      idx_hi = (cur_taps > MAX_TAPS - 1) ? MAX_TAPS - 1 : cur_taps;
      for (int n = 0; n < n_items; n++) begin
        op = ($urandom_range(0, 9) < 3) ? OP_COEF : OP_SAMPLE;
        send_item(op, ($urandom_range(0, 3) == 0)
                        ? COEF_INDEX_BITS'($urandom_range(0, MAX_TAPS - 1))
                        : COEF_INDEX_BITS'($urandom_range(0, idx_hi)),
                  random_value(), 1'b0, '0);
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("fir_impulse_response_convolver_core test passed");
    end else begin
      $display("fir_impulse_response_convolver_core test failed");
    end
    $finish;
  end

endmodule
